// ----- sv/pdeb_pkg.sv -----
`default_nettype none
package pdeb_pkg;

  localparam int PIN_W     = 16;
  localparam int PIN_COUNT = 16;
  localparam int TIME_W    = 32;
  localparam int WIN_W     = 16;
  localparam int CMD_W     = 2;

  localparam logic [PIN_W-1:0] PIN_MASK = PIN_W'((1 << PIN_COUNT) - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_SNAPSHOT = 2'd0,
    CMD_RAW_READ = 2'd1,
    CMD_SCAN     = 2'd2
  } cmd_t;

  localparam logic [0:0] REG_WINDOW = 1'b0;
  localparam logic [0:0] REG_MODE   = 1'b1;

  localparam logic MODE_POLLING = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [PIN_W-1:0]  raw_pins;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [PIN_W-1:0] levels;
    logic [PIN_W-1:0] rising_edges;
    logic [PIN_W-1:0] falling_edges;
    logic [PIN_W-1:0] pending_mask;
    logic             settled;
  } result_t;

  // per-pin status handed from a lane to the merge logic
  typedef struct packed {
    logic pending;
    logic level_next;
    logic pending_next;
  } lane_stat_t;

endpackage
`default_nettype wire

// ----- sv/pdeb_lane.sv -----
`default_nettype none
module pdeb_lane (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        commit,
  input  wire logic                        raw_bit,
  input  wire logic                        cur_bit,
  input  wire logic [pdeb_pkg::TIME_W-1:0] now_ms,
  input  wire logic [pdeb_pkg::WIN_W-1:0]  window,
  output pdeb_pkg::lane_stat_t             stat
);
  import pdeb_pkg::*;

  logic              pending;
  logic [TIME_W-1:0] stamp;
  logic              differs;
  logic              pend_eff;
  logic [TIME_W-1:0] stamp_eff;
  logic [TIME_W-1:0] elapsed;
  logic              done;

  always_comb begin
    differs   = raw_bit ^ cur_bit;
    pend_eff  = pending | differs;
    stamp_eff = (differs && !pending) ? now_ms : stamp;
    elapsed   = now_ms - stamp_eff;
    done      = pend_eff && ((window == '0) || (elapsed >= {{(TIME_W-WIN_W){1'b0}}, window}));
  end

  assign stat.pending      = pending;
  assign stat.level_next   = done ? raw_bit : cur_bit;
  assign stat.pending_next = pend_eff && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      stamp   <= '0;
    end else if (commit) begin
      pending <= pend_eff && !done;
      stamp   <= done ? '0 : stamp_eff;
    end
  end

endmodule
`default_nettype wire

// ----- sv/pdeb_out.sv -----
`default_nettype none
module pdeb_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire pdeb_pkg::result_t word,
  output logic                   full,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output pdeb_pkg::result_t      result
);
  import pdeb_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    drain;

  assign full  = skid_valid;
  assign drain = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (push) begin
      if (drain) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (drain) begin
      result_valid <= skid_valid;
      skid_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (drain) begin
        result <= word;
      end else begin
        skid <= word;
      end
    end else if (drain && skid_valid) begin
      result <= skid;
    end
  end

endmodule
`default_nettype wire

// ----- sv/per_pin_timed_debounce_edges_top.sv -----
// An accepted word is registered into the result register, or into the skid register if
// that holds a stalled word. Throughput: one sample word per cycle while sample_stall is
// low; sixteen parallel lanes resolve all pins, each with a 32-bit elapsed-time compare.
// sample_stall rises only while the output skid register holds a word, i.e. when a
// second word arrives while the result register still holds a stalled word.
// Reset (rst, synchronous): levels, baseline, pending marks and timestamps clear to zero.
`default_nettype none
module per_pin_timed_debounce_edges_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [pdeb_pkg::WIN_W-1:0] cfg_data,
  input  wire logic                       sample_valid,
  output logic                            sample_stall,
  input  wire pdeb_pkg::sample_t          sample,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output pdeb_pkg::result_t               result
);
  import pdeb_pkg::*;

  // configuration
  logic [WIN_W-1:0] window;
  logic             scan_mode;

  // confirmed levels and edge baseline
  logic [PIN_W-1:0] levels;
  logic [PIN_W-1:0] baseline;
  logic [PIN_W-1:0] levels_next;
  logic [PIN_W-1:0] baseline_next;
  logic [PIN_W-1:0] pend_out;

  logic             accept;
  logic             is_scan;
  logic [PIN_W-1:0] raw;
  lane_stat_t       lane [PIN_W];
  logic [PIN_W-1:0] lane_pending;
  logic [PIN_W-1:0] lane_level_next;
  logic [PIN_W-1:0] lane_pending_next;
  result_t          word;

  assign accept  = sample_valid && !sample_stall;
  assign is_scan = (sample.command == CMD_SCAN);
  // drop raw bits of pins that do not exist
  assign raw     = sample.raw_pins & PIN_MASK;

  // Configuration writes: decode the register index.
  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      scan_mode <= MODE_POLLING;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW: window    <= cfg_data;
        REG_MODE:   scan_mode <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // One debounce lane per pin; lanes past the pin count read as idle zeros.
  for (genvar g = 0; g < PIN_W; g++) begin : g_lane
    if (g < PIN_COUNT) begin : g_pin
      pdeb_lane u_lane (
        .clk     (clk),
        .rst     (rst),
        .commit  (accept && is_scan),
        .raw_bit (raw[g]),
        .cur_bit (levels[g]),
        .now_ms  (sample.now_ms),
        .window  (window),
        .stat    (lane[g])
      );
    end else begin : g_none
      assign lane[g] = '0;
    end
    assign lane_pending[g]      = lane[g].pending;
    assign lane_level_next[g]   = lane[g].level_next;
    assign lane_pending_next[g] = lane[g].pending_next;
  end

  // Merge stage: apply the command to the shared level and baseline words.
  always_comb begin
    levels_next   = levels;
    baseline_next = baseline;
    pend_out      = lane_pending;
    case (sample.command)
      CMD_SNAPSHOT: begin
        levels_next   = raw;
        baseline_next = raw;
      end
      CMD_RAW_READ: begin
        if (raw != levels) begin
          baseline_next = levels;
          levels_next   = raw;
        end
      end
      CMD_SCAN: begin
        // in interrupt mode hold the baseline while any pin is pending
        if (scan_mode == MODE_POLLING || lane_pending == '0) begin
          baseline_next = levels;
        end
        levels_next = lane_level_next;
        pend_out    = lane_pending_next;
      end
      default: ;
    endcase
  end

  always_comb begin
    word.levels        = levels_next;
    word.rising_edges  = levels_next & ~baseline_next;
    word.falling_edges = ~levels_next & baseline_next;
    word.pending_mask  = pend_out;
    word.settled       = (pend_out == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels   <= '0;
      baseline <= '0;
    end else if (accept) begin
      levels   <= levels_next;
      baseline <= baseline_next;
    end
  end

  // Output register plus skid stage; stall the sample side only when the skid is full.
  pdeb_out u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .word         (word),
    .full         (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted sample produced no result");

  a_settled_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.settled == (result.pending_mask == '0)))
    else $error("settled flag disagrees with pending mask");

  a_edges_disjoint: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.rising_edges & result.falling_edges) == '0))
    else $error("pin reported rising and falling at once");

  a_pending_tracks_lanes: assert property (@(posedge clk) disable iff (rst)
    (accept && is_scan) |=> (lane_pending == $past(lane_pending_next)))
    else $error("lane pending marks did not follow scan result");
`endif

endmodule
`default_nettype wire

// ----- sim/pdeb_edge_monitor.sv -----
`timescale 1ns / 100ps
module pdeb_edge_monitor
  import pdeb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [WIN_W-1:0]  cfg_data,
  input  logic              sample_valid,
  input  logic              sample_stall,
  input  sample_t           sample,
  input  logic              result_valid,
  input  logic              result_stall,
  input  result_t           result,
  output int                fail_count,
  output int                words_owed
);

  logic [PIN_W-1:0]  lvl_q;
  logic [PIN_W-1:0]  base_q;
  logic [PIN_W-1:0]  pend_q;
  logic [TIME_W-1:0] stamp_q [PIN_COUNT];
  logic [WIN_W-1:0]  window_q;
  logic              mode_q;
  result_t           owed_q [$];

  initial begin
    fail_count = 0;
    words_owed = 0;
  end

  // Apply one sample word to the shadow pin state and return the status word it yields.
  function automatic result_t advance_pins(sample_t s);
    logic [PIN_W-1:0]  raw;
    logic [PIN_W-1:0]  diff;
    logic [TIME_W-1:0] elapsed;
    result_t           r;
    raw = s.raw_pins & PIN_MASK;
    case (s.command)
      CMD_SNAPSHOT: begin
        lvl_q  = raw;
        base_q = raw;
      end
      CMD_RAW_READ: begin
        if (raw != lvl_q) begin
          base_q = lvl_q;
          lvl_q  = raw;
        end
      end
      CMD_SCAN: begin
        if (mode_q == MODE_POLLING || pend_q == '0) begin
          base_q = lvl_q;
        end
        diff = raw ^ lvl_q;
        for (int i = 0; i < PIN_COUNT; i++) begin
          if (diff[i] && !pend_q[i]) begin
            stamp_q[i] = s.now_ms;
            pend_q[i]  = 1'b1;
          end
          if (pend_q[i]) begin
            elapsed = s.now_ms - stamp_q[i];
            if (window_q == '0 || elapsed >= TIME_W'(window_q)) begin
              lvl_q[i]   = raw[i];
              pend_q[i]  = 1'b0;
              stamp_q[i] = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.levels        = lvl_q;
    r.rising_edges  = lvl_q & ~base_q;
    r.falling_edges = ~lvl_q & base_q;
    r.pending_mask  = pend_q;
    r.settled       = (pend_q == '0);
    return r;
  endfunction

  task automatic check_field(string name, logic [PIN_W-1:0] want, logic [PIN_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      lvl_q    = '0;
      base_q   = '0;
      pend_q   = '0;
      window_q = '0;
      mode_q   = MODE_POLLING;
      for (int i = 0; i < PIN_COUNT; i++) begin
        stamp_q[i] = '0;
      end
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW: window_q = cfg_data;
          REG_MODE:   mode_q   = cfg_data[0];
          default:    ;
        endcase
      end
      if (sample_valid && !sample_stall) begin
        owed_q.push_back(advance_pins(sample));
      end
      if (result_valid && !result_stall) begin
        got = result;
        if (owed_q.size() == 0) begin
          $error("result word with nothing owed: %h", got);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          check_field("levels", want.levels, got.levels);
          check_field("rising_edges", want.rising_edges, got.rising_edges);
          check_field("falling_edges", want.falling_edges, got.falling_edges);
          check_field("pending_mask", want.pending_mask, got.pending_mask);
          check_field("settled", PIN_W'(want.settled), PIN_W'(got.settled));
        end
      end
    end
    words_owed = owed_q.size();
  end

endmodule

// ----- sim/per_pin_timed_debounce_edges_top_tb.sv -----
`timescale 1ns / 100ps
module per_pin_timed_debounce_edges_top_tb;
  import pdeb_pkg::*;

  // Command code the block has no name for; it must only report.
  localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
  localparam logic             MODE_INTERRUPT = ~MODE_POLLING;
  localparam int               RUN_LIMIT      = 500_000;
  localparam int               HOLD_CYCLES    = 60;
  localparam int               PHASE_WORDS    = 130;
  localparam int               PHASES         = 8;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [0:0]        cfg_index;
  logic [WIN_W-1:0]  cfg_data;
  logic              sample_valid;
  logic              sample_stall;
  sample_t           sample;
  logic              result_valid;
  logic              result_stall;
  result_t           result;

  int                fail_count;
  int                words_owed;
  int                cycles = 0;
  int                hold_ask;

  // Generator state: a running clock in ms, the last raw pin pattern and the live window.
  logic [TIME_W-1:0] t_ms;
  logic [PIN_W-1:0]  raw_last;
  int                win_now;

  // Settings swept by the random phases, the extremes of both registers among them.
  int   phase_window [PHASES] = '{1, 0, 7, 65535, 3, 65535, 20, 0};
  logic phase_mode   [PHASES] = '{MODE_POLLING, MODE_INTERRUPT, MODE_INTERRUPT, MODE_POLLING,
                                  MODE_POLLING, MODE_INTERRUPT, MODE_INTERRUPT, MODE_POLLING};

  per_pin_timed_debounce_edges_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Watch both channels and the register port; predict and compare every result word.
  pdeb_edge_monitor u_edge_monitor (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .words_owed   (words_owed)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Guard against a hung handshake: stop the run at a generous cycle budget.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("per_pin_timed_debounce_edges_top verification failed");
      $finish;
    end
  end

  function automatic sample_t word_of(logic [CMD_W-1:0] c, logic [PIN_W-1:0] r,
                                      logic [TIME_W-1:0] t);
    sample_t s;
    s.command  = c;
    s.raw_pins = r;
    s.now_ms   = t;
    return s;
  endfunction

  // Mostly back-to-back words, some short gaps and a few long ones.
  function automatic int pick_gap(bit burst);
    int p;
    if (burst) begin
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 55) begin
      return 0;
    end else if (p < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 20);
  endfunction

  // Build the next random word: mostly scans of a bouncing pin pattern on a clock that
  // advances in steps near the window, so pins go pending and then commit. Snapshots,
  // raw reads, the unused code, clock jumps and wraps are mixed in as noise.
  function automatic sample_t next_word();
    sample_t s;
    int      p;
    int      span;
    span = win_now + win_now / 2 + 1;
    p = $urandom_range(0, 99);
    if (p < 4) begin
      s.command = CMD_SNAPSHOT;
    end else if (p < 12) begin
      s.command = CMD_RAW_READ;
    end else if (p < 97) begin
      s.command = CMD_SCAN;
    end else begin
      s.command = CMD_UNUSED;
    end
    p = $urandom_range(0, 99);
    if (p < 45) begin
      raw_last ^= PIN_W'(1) << $urandom_range(0, PIN_W - 1);
    end else if (p < 60) begin
      raw_last ^= PIN_W'($urandom) & PIN_W'($urandom) & PIN_W'($urandom);
    end else if (p < 90) begin
      raw_last = raw_last;
    end else begin
      raw_last = PIN_W'($urandom);
    end
    s.raw_pins = raw_last;
    p = $urandom_range(0, 99);
    if (p < 85) begin
      t_ms += TIME_W'($urandom_range(0, span));
    end else if (p < 93) begin
      t_ms = t_ms;
    end else if (p < 97) begin
      t_ms = TIME_W'($urandom);
    end else begin
      t_ms = '1 - TIME_W'($urandom_range(0, span));
    end
    s.now_ms = t_ms;
    return s;
  endfunction

  // Offer one word and hold it until accepted; then idle for gap cycles, or leave
  // valid high so the next call follows in the same cycle.
  task automatic send_word(sample_t s, int gap);
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) begin
      @(posedge clk);
    end
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every owed result word has come back, plus the latency.
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    wait (words_owed == 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [WIN_W-1:0] val);
    drain();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_WINDOW) begin
      win_now = int'(val);
    end
  endtask

  // Receiver: random stall pattern, plus a long hold-off whenever the sender asks.
  initial begin
    int hold_seen;
    int p;
    hold_seen = 0;
    result_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        p = $urandom_range(0, 19);
        if (p < 11) begin
          result_stall <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (p < 13) begin
          result_stall <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else if (p < 18) begin
          result_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          result_stall <= 1'b1;
          repeat ($urandom_range(8, 25)) @(posedge clk);
        end
      end
    end
  end

  // Sender: directed words, then the random phases, then the verdict.
  initial begin
    bit burst;
    hold_ask     = 0;
    t_ms         = '0;
    raw_last     = '0;
    win_now      = 0;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_WINDOW;
    cfg_data     <= '0;
    sample_valid <= 1'b0;
    sample       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: zero window commits at once, polling baseline.
    send_word(word_of(CMD_SNAPSHOT, '1, '0), 0);
    send_word(word_of(CMD_SNAPSHOT, '0, '1), 1);
    // raw read of an unchanged pattern must not move the baseline
    send_word(word_of(CMD_RAW_READ, '0, 32'd5), 0);
    send_word(word_of(CMD_RAW_READ, 16'hA5A5, 32'd6), 0);
    send_word(word_of(CMD_SCAN, 16'h5A5A, 32'd10), 2);
    send_word(word_of(CMD_UNUSED, '1, '1), 0);
    send_word(word_of(CMD_SCAN, 16'h5A5A, 32'd11), 0);

    // Widest window in interrupt mode: stamp just below the wrap, commit across it.
    write_reg(REG_WINDOW, '1);
    write_reg(REG_MODE, WIN_W'(MODE_INTERRUPT));
    send_word(word_of(CMD_SNAPSHOT, '0, '0), 0);
    send_word(word_of(CMD_SCAN, '1, 32'hFFFF_FFF0), 0);
    send_word(word_of(CMD_SCAN, '0, 32'h0000_0000), 0);
    send_word(word_of(CMD_RAW_READ, '1, 32'h0000_0001), 0);
    // one ms short of the window, then exactly on it
    send_word(word_of(CMD_SCAN, '1, 32'h0000_FFEE), 0);
    send_word(word_of(CMD_SCAN, '0, 32'h0000_FFEF), 0);
    send_word(word_of(CMD_SCAN, 16'h0001, 32'h0000_0001), 0);
    send_word(word_of(CMD_SCAN, 16'h8000, 32'h7FFF_FFFF), 3);
    send_word(word_of(CMD_UNUSED, '0, '0), 0);
    send_word(word_of(CMD_SCAN, 16'h8001, 32'h8000_FFFF), 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_WINDOW, WIN_W'(phase_window[ph]));
      write_reg(REG_MODE, WIN_W'(phase_mode[ph]));
      raw_last = PIN_W'($urandom);
      t_ms     = TIME_W'($urandom);
      send_word(word_of(CMD_SNAPSHOT, raw_last, t_ms), pick_gap(1'b0));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // hold the sender until every owed word is back, mid phase
        if (n == PHASE_WORDS / 2) begin
          drain();
        end
        // in one phase, stall the receiver long while words keep coming back-to-back
        if (ph == 2 && n == 30) begin
          hold_ask = hold_ask + 1;
        end
        burst = (ph == 2 && n >= 30 && n < 64) || (n % 40 < 8);
        send_word(next_word(), pick_gap(burst));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("per_pin_timed_debounce_edges_top verification clean");
    end else begin
      $display("per_pin_timed_debounce_edges_top verification failed");
    end
    $finish;
  end

endmodule
